@@ src/isq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package isq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int POS_W        = 6;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 7;

    typedef enum logic [3:0] {
        K_PUSH_TAIL  = 4'd0,
        K_PUSH_HEAD  = 4'd1,
        K_POP_TAIL   = 4'd2,
        K_POP_HEAD   = 4'd3,
        K_READ       = 4'd4,
        K_INSERT     = 4'd5,
        K_REMOVE     = 4'd6,
        K_OVERWRITE  = 4'd7,
        K_CLEAR      = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_RANGE = 2'd2,
        ERR_FULL  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOP,
        S_SHIFT_WR,
        S_PLACE,
        S_READ,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PS_IN,
        PS_COUNT,
        PS_LAST,
        PS_ZERO
    } pos_sel_t;

    typedef struct packed {
        logic     load;
        logic     back;
        pos_sel_t pos_sel;
        logic     shift_rd;
        logic     shift_wr;
        logic     place_wr;
        logic     pos_rd;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     cnt_clr;
        logic     out_load;
        logic     rd_sel;
        err_t     err;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic pos_out;
        logic more;
        logic out_stall;
    } stat_t;

endpackage

`default_nettype wire

@@ src/isq_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module isq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [3:0]    kind,
    input  wire isq_pkg::stat_t status,
    output isq_pkg::cmd_t      cmd
);

    isq_pkg::state_t state_reg, state_next;
    isq_pkg::kind_t  kind_reg, kind_next;
    isq_pkg::err_t   err_reg, err_next;
    isq_pkg::kind_t  kind_in;
    isq_pkg::err_t   err_in;

    assign kind_in = isq_pkg::kind_t'(kind);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isq_pkg::S_IDLE;
            kind_reg  <= isq_pkg::K_CLEAR;
            err_reg   <= isq_pkg::ERR_OK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            err_reg   <= err_next;
        end
    end

    // check the request against the current fill
    always_comb
    begin
        err_in = isq_pkg::ERR_OK;
        case (kind_in)
            isq_pkg::K_PUSH_TAIL, isq_pkg::K_PUSH_HEAD:
            begin
                if (status.full)
                    err_in = isq_pkg::ERR_FULL;
            end
            isq_pkg::K_POP_TAIL, isq_pkg::K_POP_HEAD:
            begin
                if (status.empty)
                    err_in = isq_pkg::ERR_EMPTY;
            end
            isq_pkg::K_READ, isq_pkg::K_REMOVE, isq_pkg::K_OVERWRITE,
            isq_pkg::K_INSERT:
            begin
                if (status.empty)
                    err_in = isq_pkg::ERR_EMPTY;
                else if (status.pos_out)
                    err_in = isq_pkg::ERR_RANGE;
                else if (kind_in == isq_pkg::K_INSERT && status.full)
                    err_in = isq_pkg::ERR_FULL;
            end
            default:
                err_in = isq_pkg::ERR_OK;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        err_next   = err_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.err    = err_reg;
        case (state_reg)
            isq_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    kind_next = kind_in;
                    err_next  = err_in;
                    case (kind_in)
                        isq_pkg::K_PUSH_TAIL:
                        begin
                            cmd.back    = 1'b1;
                            cmd.pos_sel = isq_pkg::PS_COUNT;
                        end
                        isq_pkg::K_PUSH_HEAD:
                        begin
                            cmd.back    = 1'b1;
                            cmd.pos_sel = isq_pkg::PS_ZERO;
                        end
                        isq_pkg::K_INSERT:
                        begin
                            cmd.back    = 1'b1;
                            cmd.pos_sel = isq_pkg::PS_IN;
                        end
                        isq_pkg::K_POP_TAIL:
                            cmd.pos_sel = isq_pkg::PS_LAST;
                        isq_pkg::K_POP_HEAD:
                            cmd.pos_sel = isq_pkg::PS_ZERO;
                        default:
                            cmd.pos_sel = isq_pkg::PS_IN;
                    endcase
                    if (err_in != isq_pkg::ERR_OK)
                        state_next = isq_pkg::S_DONE;
                    else
                    begin
                        case (kind_in)
                            isq_pkg::K_PUSH_TAIL, isq_pkg::K_PUSH_HEAD,
                            isq_pkg::K_INSERT, isq_pkg::K_POP_TAIL,
                            isq_pkg::K_POP_HEAD, isq_pkg::K_REMOVE:
                                state_next = isq_pkg::S_LOOP;
                            isq_pkg::K_READ:
                                state_next = isq_pkg::S_READ;
                            isq_pkg::K_OVERWRITE:
                                state_next = isq_pkg::S_PLACE;
                            default:
                                state_next = isq_pkg::S_DONE;
                        endcase
                    end
                end
            end
            isq_pkg::S_LOOP:
            begin
                if (status.more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = isq_pkg::S_SHIFT_WR;
                end
                else if (kind_reg == isq_pkg::K_PUSH_TAIL ||
                         kind_reg == isq_pkg::K_PUSH_HEAD ||
                         kind_reg == isq_pkg::K_INSERT)
                    state_next = isq_pkg::S_PLACE;
                else
                    state_next = isq_pkg::S_DONE;
            end
            isq_pkg::S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = isq_pkg::S_LOOP;
            end
            isq_pkg::S_PLACE:
            begin
                cmd.place_wr = 1'b1;
                state_next   = isq_pkg::S_DONE;
            end
            isq_pkg::S_READ:
            begin
                cmd.pos_rd = 1'b1;
                state_next = isq_pkg::S_DONE;
            end
            isq_pkg::S_DONE:
            begin
                if (!status.out_stall)
                begin
                    cmd.out_load = 1'b1;
                    if (err_reg == isq_pkg::ERR_OK)
                    begin
                        case (kind_reg)
                            isq_pkg::K_PUSH_TAIL, isq_pkg::K_PUSH_HEAD,
                            isq_pkg::K_INSERT:
                                cmd.cnt_inc = 1'b1;
                            isq_pkg::K_POP_TAIL, isq_pkg::K_POP_HEAD,
                            isq_pkg::K_REMOVE:
                                cmd.cnt_dec = 1'b1;
                            isq_pkg::K_CLEAR:
                                cmd.cnt_clr = 1'b1;
                            isq_pkg::K_READ:
                                cmd.rd_sel = 1'b1;
                            default:
                                cmd.rd_sel = 1'b0;
                        endcase
                    end
                    state_next = isq_pkg::S_IDLE;
                end
            end
            default:
                state_next = isq_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ src/isq_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module isq_datapath #(
    parameter int CAPACITY = isq_pkg::DEF_CAPACITY
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire isq_pkg::cmd_t                         cmd,
    output isq_pkg::stat_t                             status,
    input  wire logic [isq_pkg::POS_W-1:0]             position,
    input  wire logic signed [isq_pkg::DATA_W-1:0]     value,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [isq_pkg::DATA_W-1:0]          read_value,
    output logic [isq_pkg::COUNT_OUT_W-1:0]            count,
    output logic                                       empty_res,
    output logic [1:0]                                 error
);

    localparam int AW   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > isq_pkg::POS_W) ? CW : isq_pkg::POS_W;
    localparam int OW   = CW + isq_pkg::COUNT_OUT_W;

    logic [isq_pkg::DATA_W-1:0] mem [CAPACITY];
    logic [isq_pkg::DATA_W-1:0] rdata_reg;
    logic [isq_pkg::DATA_W-1:0] val_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          back_reg;

    logic                               out_valid_reg;
    logic [isq_pkg::DATA_W-1:0]         read_value_reg;
    logic [isq_pkg::COUNT_OUT_W-1:0]    count_out_reg;
    logic                               empty_reg;
    isq_pkg::err_t                      error_reg;

    logic [CMPW-1:0] pos_cmp;
    logic [CMPW-1:0] cnt_cmp;
    logic [CW-1:0]   last_w;
    logic [CW-1:0]   idx_plus;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic [isq_pkg::DATA_W-1:0] wr_data;
    logic            wr_en;
    logic [OW-1:0]   count_wide;

    assign pos_cmp  = CMPW'(position);
    assign cnt_cmp  = CMPW'(count_reg);
    assign last_w   = count_reg - CW'(1);
    assign idx_plus = CW'(idx_reg) + CW'(1);

    assign status.empty     = (count_reg == '0);
    assign status.full      = (count_reg >= CW'(CAPACITY));
    assign status.pos_out   = (pos_cmp >= cnt_cmp);
    assign status.more      = back_reg ? (idx_reg > pos_reg) : (idx_plus < count_reg);
    assign status.out_stall = out_valid_reg && !out_ready;

    always_comb
    begin
        case (cmd.pos_sel)
            isq_pkg::PS_IN:    pos_next = pos_cmp[AW-1:0];
            isq_pkg::PS_COUNT: pos_next = count_reg[AW-1:0];
            isq_pkg::PS_LAST:  pos_next = last_w[AW-1:0];
            isq_pkg::PS_ZERO:  pos_next = '0;
            default:           pos_next = '0;
        endcase
    end

    // walk the index toward the target while moving elements
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.load)
            idx_next = cmd.back ? count_reg[AW-1:0] : pos_next;
        else if (cmd.shift_wr)
            idx_next = back_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));
    end

    always_comb
    begin
        if (cmd.cnt_clr)
            count_next = '0;
        else if (cmd.cnt_inc)
            count_next = count_reg + CW'(1);
        else if (cmd.cnt_dec)
            count_next = count_reg - CW'(1);
        else
            count_next = count_reg;
    end

    assign count_wide = OW'(count_next);

    assign rd_addr = cmd.shift_rd ? (back_reg ? (idx_reg - AW'(1)) : (idx_reg + AW'(1)))
                                  : pos_reg;
    assign wr_addr = cmd.shift_wr ? idx_reg : pos_reg;
    assign wr_data = cmd.shift_wr ? rdata_reg : val_reg;
    assign wr_en   = cmd.shift_wr || cmd.place_wr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.shift_rd || cmd.pos_rd)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg  <= value;
            pos_reg  <= pos_next;
            back_reg <= cmd.back;
        end
        idx_reg <= idx_next;
        if (cmd.out_load)
        begin
            read_value_reg <= cmd.rd_sel ? rdata_reg : '0;
            count_out_reg  <= count_wide[isq_pkg::COUNT_OUT_W-1:0];
            empty_reg      <= (count_next == '0);
            error_reg      <= cmd.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign count      = count_out_reg;
    assign empty_res  = empty_reg;
    assign error      = error_reg;

endmodule

`default_nettype wire

@@ src/indexed_sequence_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake              | Beat contents
// in      | in_valid / in_ready    | kind, position, value
// out     | out_valid / out_ready  | read_value, count, empty_res, error
//
// One request at a time; the element store is a single memory with one read
// and one write port, so each element moved takes a read (S_LOOP) and then a
// write (S_SHIFT_WR). Insert and push front move the elements from the position
// onward up one place before the value is written; remove and pop front move the
// elements behind the position down one place. Push back writes in place.
// Reset clears the count and the control; the memory needs no clearing pass.
// A stalled result holds in the output register; the next beat is taken then.

module indexed_sequence_store #(
    parameter int CAPACITY = isq_pkg::DEF_CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [3:0]                        kind,
    input  wire logic [isq_pkg::POS_W-1:0]         position,
    input  wire logic signed [isq_pkg::DATA_W-1:0] value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [isq_pkg::DATA_W-1:0]      read_value,
    output logic [isq_pkg::COUNT_OUT_W-1:0]        count,
    output logic                                   empty_res,
    output logic [1:0]                             error
);

    isq_pkg::cmd_t  cmd;
    isq_pkg::stat_t status;

    isq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    isq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .count      (count),
        .empty_res  (empty_res),
        .error      (error)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in flight");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_res) |-> (count == '0))
        else $error("empty flag set with nonzero count");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error == isq_pkg::ERR_EMPTY) |-> empty_res)
        else $error("empty error on a sequence that holds elements");

    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error == isq_pkg::ERR_FULL && CAPACITY < 128)
            |-> (count == isq_pkg::COUNT_OUT_W'(CAPACITY)))
        else $error("full error with room left");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load) |-> !(out_valid && !out_ready))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ test/indexed_sequence_store_tb.sv @@
`timescale 1ns / 1ps

module indexed_sequence_store_tb;

    import isq_pkg::*;

    localparam int CAP            = DEF_CAPACITY;
    localparam int PHASE_ITEMS    = 500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int KIND_LAST      = 15;

    typedef struct packed {
        logic [3:0]               kind;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } seq_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] rd;
        logic [COUNT_OUT_W-1:0]   cnt;
        logic                     emp;
        err_t                     err;
    } seq_result_t;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic [3:0]                 kind       = '0;
    logic [POS_W-1:0]           position   = '0;
    logic signed [DATA_W-1:0]   value      = '0;
    logic                       out_valid;
    logic                       out_ready  = 1'b0;
    logic signed [DATA_W-1:0]   read_value;
    logic [COUNT_OUT_W-1:0]     count;
    logic                       empty_res;
    logic [1:0]                 error;

    seq_req_t                   pending_requests[$];
    seq_result_t                pending_results[$];
    seq_req_t                   next_req;
    seq_result_t                want_res;
    seq_result_t                got_res;

    logic signed [DATA_W-1:0]   shadow_elems[CAP];
    int                         shadow_len     = 0;
    int                         gen_len        = 0;
    int                         issued_total   = 0;
    int                         accepted_total = 0;
    int                         phase_items    = 0;
    int                         fail_count     = 0;
    int                         quiet_cycles   = 0;
    int                         send_idle_pct  = 0;
    int                         recv_stall_pct = 0;
    logic                       in_taken       = 1'b0;

    indexed_sequence_store #(
        .CAPACITY(CAP)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .count      (count),
        .empty_res  (empty_res),
        .error      (error)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic seq_result_t apply_request(input logic [3:0] k,
                                                  input logic [POS_W-1:0] p,
                                                  input logic signed [DATA_W-1:0] v);
        seq_result_t r;
        bit          full;
        r.rd  = '0;
        r.err = ERR_OK;
        full  = shadow_len >= CAP;
        case (k)
            K_PUSH_TAIL:
                if (full)
                    r.err = ERR_FULL;
                else
                begin
                    shadow_elems[shadow_len] = v;
                    shadow_len++;
                end
            K_PUSH_HEAD:
                if (full)
                    r.err = ERR_FULL;
                else
                begin
                    for (int i = shadow_len; i > 0; i--)
                        shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[0] = v;
                    shadow_len++;
                end
            K_POP_TAIL:
                if (shadow_len == 0)
                    r.err = ERR_EMPTY;
                else
                    shadow_len--;
            K_POP_HEAD:
                if (shadow_len == 0)
                    r.err = ERR_EMPTY;
                else
                begin
                    for (int i = 0; i + 1 < shadow_len; i++)
                        shadow_elems[i] = shadow_elems[i+1];
                    shadow_len--;
                end
            K_READ, K_INSERT, K_REMOVE, K_OVERWRITE:
                if (shadow_len == 0)
                    r.err = ERR_EMPTY;
                else if (int'(p) >= shadow_len)
                    r.err = ERR_RANGE;
                else if (k == K_READ)
                    r.rd = shadow_elems[p];
                else if (k == K_INSERT)
                begin
                    if (full)
                        r.err = ERR_FULL;
                    else
                    begin
                        for (int i = shadow_len; i > int'(p); i--)
                            shadow_elems[i] = shadow_elems[i-1];
                        shadow_elems[p] = v;
                        shadow_len++;
                    end
                end
                else if (k == K_REMOVE)
                begin
                    for (int i = int'(p); i + 1 < shadow_len; i++)
                        shadow_elems[i] = shadow_elems[i+1];
                    shadow_len--;
                end
                else
                    shadow_elems[p] = v;
            K_CLEAR:
                shadow_len = 0;
            default:
                ;
        endcase
        r.cnt = shadow_len[COUNT_OUT_W-1:0];
        r.emp = (shadow_len == 0);
        return r;
    endfunction

    task automatic add_req(input logic [3:0] k, input int p, input logic [DATA_W-1:0] v);
        seq_req_t r;
        r.kind = k;
        r.pos  = p[POS_W-1:0];
        r.val  = v;
        pending_requests.insert(pending_requests.size(), r);
        issued_total++;
        phase_items++;
        case (k)
            K_PUSH_TAIL, K_PUSH_HEAD:
                if (gen_len < CAP)
                    gen_len++;
            K_POP_TAIL, K_POP_HEAD:
                if (gen_len > 0)
                    gen_len--;
            K_INSERT:
                if (gen_len > 0 && p < gen_len && gen_len < CAP)
                    gen_len++;
            K_REMOVE:
                if (gen_len > 0 && p < gen_len)
                    gen_len--;
            K_CLEAR:
                gen_len = 0;
            default:
                ;
        endcase
    endtask

    function automatic int pick_pos(input int valid_pct);
        if (gen_len > 0 && (gen_len == CAP || $urandom_range(0, 99) < valid_pct))
            return $urandom_range(0, gen_len - 1);
        else if (gen_len < CAP)
            return $urandom_range(gen_len, (1 << POS_W) - 1);
        return $urandom_range(0, (1 << POS_W) - 1);
    endfunction

    task automatic add_mixed_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            add_req(K_READ, pick_pos(85), $urandom());
        else if (roll < 40)
            add_req(K_OVERWRITE, pick_pos(85), $urandom());
        else if (roll < 55)
            add_req(K_INSERT, pick_pos(85), $urandom());
        else if (roll < 70)
            add_req(K_REMOVE, pick_pos(85), $urandom());
        else if (roll < 78)
            add_req(K_PUSH_TAIL, pick_pos(50), $urandom());
        else if (roll < 85)
            add_req(K_PUSH_HEAD, pick_pos(50), $urandom());
        else if (roll < 90)
            add_req(K_POP_TAIL, pick_pos(50), $urandom());
        else if (roll < 95)
            add_req(K_POP_HEAD, pick_pos(50), $urandom());
        else if (roll < 97)
            add_req(K_CLEAR, pick_pos(50), $urandom());
        else
            add_req(4'($urandom_range(int'(K_CLEAR) + 1, KIND_LAST)), pick_pos(50),
                    $urandom());
    endtask

    task automatic add_fill_run();
        int roll;
        while (gen_len < CAP)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                add_req(K_PUSH_TAIL, pick_pos(50), $urandom());
            else if (roll < 60)
                add_req(K_PUSH_HEAD, pick_pos(50), $urandom());
            else if (roll < 90 && gen_len > 0)
                add_req(K_INSERT, pick_pos(100), $urandom());
            else
                add_req(K_READ, pick_pos(90), $urandom());
        end
        add_req(K_PUSH_TAIL, pick_pos(50), $urandom());
        add_req(K_PUSH_HEAD, pick_pos(50), $urandom());
        add_req(K_INSERT, pick_pos(100), $urandom());
        add_req(K_READ, CAP - 1, $urandom());
        add_req(K_OVERWRITE, CAP - 1, $urandom());
    endtask

    task automatic add_drain_run();
        int roll;
        while (gen_len > 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 30)
                add_req(K_POP_TAIL, pick_pos(50), $urandom());
            else if (roll < 60)
                add_req(K_POP_HEAD, pick_pos(50), $urandom());
            else if (roll < 90)
                add_req(K_REMOVE, pick_pos(100), $urandom());
            else if (roll < 99)
                add_req(K_READ, pick_pos(90), $urandom());
            else
                add_req(K_CLEAR, pick_pos(50), $urandom());
        end
        add_req(K_POP_TAIL, pick_pos(50), $urandom());
        add_req(K_POP_HEAD, pick_pos(50), $urandom());
        add_req(K_READ, pick_pos(50), $urandom());
        add_req(K_REMOVE, pick_pos(50), $urandom());
    endtask

    // drive on the falling edge; hold the beat until accepted
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_req = pending_requests[0];
                pending_requests.delete(0);
                kind     <= next_req.kind;
                position <= next_req.pos;
                value    <= next_req.val;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got_res.rd  = read_value;
                got_res.cnt = count;
                got_res.emp = empty_res;
                got_res.err = err_t'(error);
                if (pending_results.size() == 0)
                begin
                    $display("%0t unexpected result: read_value %0d count %0d empty %0b error %0d",
                             $time, read_value, count, empty_res, error);
                    fail_count++;
                end
                else
                begin
                    want_res = pending_results[0];
                    pending_results.delete(0);
                    if (got_res !== want_res)
                    begin
                        $display("%0t mismatch: expected rd %0d cnt %0d empty %0b err %0d",
                                 $time, want_res.rd, want_res.cnt, want_res.emp, want_res.err);
                        $display("%0t          actual   rd %0d cnt %0d empty %0b err %0d",
                                 $time, read_value, count, empty_res, error);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_results.insert(pending_results.size(),
                                       apply_request(kind, position, value));
                accepted_total++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        in_taken <= rst_n && in_valid && in_ready;
    end

    initial
    begin
        int roll;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            phase_items = 0;
            if (ph == 0)
            begin
                add_req(K_POP_TAIL, 0, 0);
                add_req(K_POP_HEAD, 63, 0);
                add_req(K_READ, 0, 0);
                add_req(K_INSERT, 0, 5);
                add_req(K_REMOVE, 0, 0);
                add_req(K_OVERWRITE, 0, 1);
                add_req(K_CLEAR, 0, 0);
                add_req(4'(KIND_LAST), 63, 32'hFFFF_FFFF);
                add_req(K_PUSH_TAIL, 0, 32'h8000_0000);
                add_req(K_PUSH_HEAD, 63, 32'h7FFF_FFFF);
                add_req(K_PUSH_TAIL, 0, 32'hFFFF_FFFF);
                add_req(K_PUSH_TAIL, 0, 0);
                add_req(K_READ, 0, 0);
                add_req(K_READ, 3, 0);
                add_req(K_READ, 4, 0);
                add_req(K_READ, 63, 0);
                add_req(K_INSERT, 3, 123);
                add_req(K_INSERT, 0, -5);
                add_req(K_OVERWRITE, 5, 32'h5A5A_A5A5);
                add_req(K_REMOVE, 5, 0);
                add_req(K_REMOVE, 0, 0);
                add_req(K_INSERT, 4, 1);
                add_req(K_POP_HEAD, 0, 0);
                add_req(K_POP_TAIL, 0, 0);
                add_req(K_CLEAR, 0, 0);
                add_req(K_PUSH_TAIL, 0, 1);
                add_req(K_POP_HEAD, 0, 0);
            end
            add_fill_run();
            while (phase_items < PHASE_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 12)
                    add_fill_run();
                else if (roll < 24)
                    add_drain_run();
                else
                    repeat ($urandom_range(20, 40)) add_mixed_op();
            end
            while (accepted_total != issued_total || pending_results.size() != 0)
                @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
